### rtl/priority_quantum_scheduler_assert.svh
// assertion macros for the priority quantum scheduler
`ifndef PRIORITY_QUANTUM_SCHEDULER_ASSERT_SVH
`define PRIORITY_QUANTUM_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqs check failed");
`define PQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqs check failed");
`else
`define PQS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PQS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/pqs_pkg.sv
// types and constants shared by the priority quantum scheduler
package pqs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActBegin  = 2'd1;
  localparam logic [1:0] ActServe  = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [23:0] ElapsedMax = 24'hFFFFFF;
  localparam logic [39:0] SumMax     = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  task_id;
    logic [15:0] burst_time;
    logic [6:0]  task_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  served_id;
    logic        finished;
    logic [23:0] elapsed;
    logic [15:0] time_left;
    logic [39:0] turnaround_sum;
    logic [15:0] step_count;
    logic [4:0]  queue_count;
  } rsp_t;

  // queue entry: id, remaining, signed priority
  typedef struct packed {
    logic [7:0]        id;
    logic [15:0]       remaining;
    logic signed [7:0] prio;
  } slot_t;

endpackage

### rtl/pqs_ram.sv
// generic ram with one write port and one registered read port
module pqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/pqs_divider.sv
// restoring divider, one quotient bit per cycle: 24-bit total by queue length
module pqs_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [23:0]             dividend_i,
  input  logic [pqs_pkg::CntW-1:0] divisor_i,
  output logic                    done_o,
  output logic [23:0]             quotient_o
);
  logic [23:0] quo_q, quo_d;
  logic [pqs_pkg::CntW:0] rem_q, rem_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [pqs_pkg::CntW:0] trial;

  assign trial = {rem_q[pqs_pkg::CntW-1:0], quo_q[23]};

  // shift and subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[22:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end
endmodule

### rtl/priority_quantum_scheduler.sv
// top level of the priority quantum scheduler
//
//  channel | direction | transfer qualifier
//  req     | in        | start && !busy
//  rsp     | out       | rsp_valid_o (one cycle)
//
// one item takes a short sequence: an insert scans the queue (SCAN, SCANW
// per entry) then shifts the tail up and writes, a begin sums the entries
// one a cycle then runs the divider, a serve pops by shifting (POPW, POP
// per entry) and reinserts an unfinished task. reset clears the state, the
// length, slice and counters, not the queue ram. the receiver cannot stall.
`include "priority_quantum_scheduler_assert.svh"
module priority_quantum_scheduler (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  pqs_pkg::req_t   req_i,
  output logic            busy,
  output logic            rsp_valid_o,
  output pqs_pkg::rsp_t   rsp_o
);
  localparam int unsigned IW = pqs_pkg::IdxW;
  localparam int unsigned CW = pqs_pkg::CntW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_SCANW  = 10'b0000000100,
    S_SHIFT  = 10'b0000001000,
    S_SHIFTW = 10'b0000010000,
    S_SUM    = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_POP    = 10'b0010000000,
    S_POPW   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] len_q, len_d, pos_q, pos_d, k_q, k_d;
  logic [15:0] slice_q, slice_d;
  logic [23:0] elapsed_q, elapsed_d, total_q, total_d;
  logic [39:0] sum_q, sum_d;
  logic [15:0] steps_q, steps_d;
  pqs_pkg::slot_t new_q, new_d;
  pqs_pkg::rsp_t rsp_q, rsp_d;
  logic valid_q, valid_d, serve_q, serve_d;

  logic we;
  logic [IW-1:0] waddr, raddr;
  pqs_pkg::slot_t wdata, rdata;
  logic div_start, div_done;
  logic [23:0] quot;

  pqs_ram #(.Width($bits(pqs_pkg::slot_t)), .Depth(pqs_pkg::QueueDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  pqs_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(total_d),
    .divisor_i (len_q),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  assign busy = (state_q != S_IDLE);
  assign rsp_valid_o = valid_q;
  assign rsp_o = rsp_q;

  // sequencer
  always_comb begin
    logic [24:0] adv;
    logic [40:0] s;
    logic [15:0] rem;
    state_d = state_q; len_d = len_q; pos_d = pos_q; k_d = k_q;
    slice_d = slice_q; elapsed_d = elapsed_q; total_d = total_q;
    sum_d = sum_q; steps_d = steps_q; new_d = new_q; rsp_d = rsp_q;
    valid_d = 1'b0; serve_d = serve_q;
    we = 1'b0; waddr = pos_q[IW-1:0]; wdata = new_q; raddr = k_q[IW-1:0];
    div_start = 1'b0;
    adv = '0; s = '0; rem = '0;
    unique case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (start) begin
          rsp_d = '0;
          serve_d = 1'b0;
          unique case (req_i.action)
            pqs_pkg::ActInsert: begin
              if (len_q >= CW'(pqs_pkg::QueueDepth)) begin
                rsp_d.status = pqs_pkg::StFull;
                state_d = S_DONE;
              end else begin
                new_d = '{id: req_i.task_id, remaining: req_i.burst_time,
                          prio: {1'b0, req_i.task_priority}};
                pos_d = '0;
                state_d = S_SCAN;
              end
            end
            pqs_pkg::ActBegin: begin
              total_d = '0; k_d = '0;
              elapsed_d = '0; sum_d = '0; steps_d = '0;
              state_d = S_SUM;
            end
            pqs_pkg::ActServe: begin
              if (len_q == '0) begin
                rsp_d.status = pqs_pkg::StEmpty;
                state_d = S_DONE;
              end else begin
                k_d = '0;
                state_d = S_POPW;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // find first slot with lower priority
      S_SCAN: begin
        raddr = pos_q[IW-1:0];
        if (pos_q == len_q) begin
          k_d = len_q;
          state_d = S_SHIFT;
        end else begin
          state_d = S_SCANW;
        end
      end
      S_SCANW: begin
        raddr = pos_q[IW-1:0];
        if (rdata.prio >= new_q.prio) begin
          pos_d = pos_q + 1'b1;
          state_d = S_SCAN;
        end else begin
          k_d = len_q;
          state_d = S_SHIFT;
        end
      end
      // shift tail up one slot, then write new entry
      S_SHIFT: begin
        raddr = IW'(k_q - 1'b1);
        if (k_q == pos_q) begin
          we = 1'b1;
          waddr = pos_q[IW-1:0];
          len_d = len_q + 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFTW;
        end
      end
      S_SHIFTW: begin
        raddr = IW'(k_q - 1'b1);
        we = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rdata;
        k_d = k_q - 1'b1;
        state_d = S_SHIFT;
      end
      // accumulate remaining times
      S_SUM: begin
        raddr = k_q[IW-1:0];
        if (k_q != '0) total_d = total_q + 24'(rdata.remaining);
        if (k_q == len_q) begin
          if (len_q == '0) begin
            slice_d = '0;
            state_d = S_DONE;
          end else begin
            div_start = 1'b1;
            state_d = S_DIV;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          slice_d = quot[15:0];
          state_d = S_DONE;
        end
      end
      // read head (k=0) then shift remaining entries down
      S_POPW: begin
        raddr = IW'(k_q + 1'b1);
        if (k_q == '0) begin
          new_d = rdata;
          rsp_d.served_id = rdata.id;
          if (rdata.remaining <= slice_q) begin
            adv = 25'(rdata.remaining);
            rsp_d.finished = 1'b1;
            serve_d = 1'b0;
          end else begin
            adv = 25'(slice_q);
            rem = rdata.remaining - slice_q;
            rsp_d.time_left = rem;
            new_d.remaining = rem;
            new_d.prio = (rdata.prio == -8'sd128) ? -8'sd128 : rdata.prio - 8'sd1;
            serve_d = 1'b1;
          end
          adv = adv + 25'(elapsed_q);
          elapsed_d = adv[24] ? pqs_pkg::ElapsedMax : adv[23:0];
          s = 41'(sum_q) + 41'(elapsed_d);
          sum_d = s[40] ? pqs_pkg::SumMax : s[39:0];
          if (steps_q != 16'hFFFF) steps_d = steps_q + 16'd1;
          state_d = S_POP;
        end else begin
          we = 1'b1;
          waddr = IW'(k_q - 1'b1);
          wdata = rdata;
          state_d = S_POP;
        end
      end
      S_POP: begin
        raddr = IW'(k_q + 1'b1);
        if (k_q + 1'b1 >= len_q) begin
          len_d = len_q - 1'b1;
          if (serve_q) begin
            pos_d = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_POPW;
        end
      end
      S_DONE: begin
        rsp_d.elapsed = elapsed_q;
        rsp_d.turnaround_sum = sum_q;
        rsp_d.step_count = steps_q;
        rsp_d.queue_count = 5'(len_q);
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; len_q <= '0; slice_q <= '0; elapsed_q <= '0;
      sum_q <= '0; steps_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; len_q <= len_d; slice_q <= slice_d;
      elapsed_q <= elapsed_d; sum_q <= sum_d; steps_q <= steps_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; k_q <= k_d; total_q <= total_d;
    new_q <= new_d; rsp_q <= rsp_d; serve_q <= serve_d;
  end

  `PQS_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= CW'(pqs_pkg::QueueDepth))
  `PQS_ASSERT_NXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE, valid_q)
  `PQS_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
endmodule

### verif/priority_quantum_scheduler_tb.sv
// testbench for the priority quantum scheduler: directed table, then random traffic
`timescale 1ns / 1ps
module priority_quantum_scheduler_tb;
  import pqs_pkg::*;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  req_t  req_i;
  logic  busy;
  logic  rsp_valid_o;
  rsp_t  rsp_o;

  priority_quantum_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // scheduler state mirror
  slot_t       sched_q[$];
  logic [15:0] sched_slice;
  logic [23:0] sched_clock;
  logic [39:0] sched_sum;
  logic [15:0] sched_steps;

  rsp_t        pending_rsp[$];
  int          errors;
  int          n_rsp;
  int          n_full;
  int          n_empty;
  int          n_fin;
  longint      cycle;

  function automatic void queue_place(slot_t s);
    int pos;
    pos = 0;
    while (pos < sched_q.size() && sched_q[pos].prio >= s.prio) pos++;
    sched_q.insert(pos, s);
  endfunction

  function automatic rsp_t sched_predict(req_t r);
    rsp_t   o;
    slot_t  h;
    longint total;
    longint acc;
    o = '0;
    if (r.action == ActInsert) begin
      if (sched_q.size() >= QueueDepth) o.status = StFull;
      else queue_place('{id: r.task_id, remaining: r.burst_time,
                         prio: $signed({1'b0, r.task_priority})});
    end else if (r.action == ActBegin) begin
      total = 0;
      foreach (sched_q[k]) total += sched_q[k].remaining;
      sched_slice = sched_q.size() ? 16'(total / sched_q.size()) : 16'd0;
      sched_clock = '0;
      sched_sum = '0;
      sched_steps = '0;
    end else if (r.action == ActServe) begin
      if (sched_q.size() == 0) o.status = StEmpty;
      else begin
        h = sched_q.pop_front();
        o.served_id = h.id;
        if (h.remaining <= sched_slice) begin
          acc = longint'(sched_clock) + h.remaining;
          o.finished = 1'b1;
        end else begin
          acc = longint'(sched_clock) + sched_slice;
          h.remaining = h.remaining - sched_slice;
          if (h.prio != -8'sd128) h.prio = h.prio - 8'sd1;
          o.time_left = h.remaining;
          queue_place(h);
        end
        sched_clock = (acc > ElapsedMax) ? ElapsedMax : 24'(acc);
        acc = longint'(sched_sum) + sched_clock;
        sched_sum = (acc > SumMax) ? SumMax : 40'(acc);
        if (sched_steps != 16'hFFFF) sched_steps++;
      end
    end
    o.elapsed = sched_clock;
    o.turnaround_sum = sched_sum;
    o.step_count = sched_steps;
    o.queue_count = 5'(sched_q.size());
    return o;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result %h", $time, rsp_o);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.status != e.status)
          $display("%0t status exp %0d got %0d", $time, e.status, rsp_o.status);
        if (rsp_o.served_id != e.served_id)
          $display("%0t served_id exp %0d got %0d", $time, e.served_id, rsp_o.served_id);
        if (rsp_o.finished != e.finished)
          $display("%0t finished exp %0d got %0d", $time, e.finished, rsp_o.finished);
        if (rsp_o.elapsed != e.elapsed)
          $display("%0t elapsed exp %0d got %0d", $time, e.elapsed, rsp_o.elapsed);
        if (rsp_o.time_left != e.time_left)
          $display("%0t time_left exp %0d got %0d", $time, e.time_left, rsp_o.time_left);
        if (rsp_o.turnaround_sum != e.turnaround_sum)
          $display("%0t turnaround_sum exp %0d got %0d", $time, e.turnaround_sum,
                   rsp_o.turnaround_sum);
        if (rsp_o.step_count != e.step_count)
          $display("%0t step_count exp %0d got %0d", $time, e.step_count, rsp_o.step_count);
        if (rsp_o.queue_count != e.queue_count)
          $display("%0t queue_count exp %0d got %0d", $time, e.queue_count,
                   rsp_o.queue_count);
        if (rsp_o != e) errors++;
        if (e.status == StFull) n_full++;
        if (e.status == StEmpty) n_empty++;
        if (e.finished) n_fin++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > 64'd2000000) begin
      $display("timeout after %0d cycles", cycle);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one transfer, with an optional random gap before it
  task automatic send_item(req_t r, logic has_exp, rsp_t exp_r);
    int gap;
    rsp_t p;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
    // start was dropped at the last transfer edge, so step off it first
    repeat (gap + 1) @(posedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = sched_predict(r);
    if (has_exp && p != exp_r) begin
      $display("%0t table row exp %h predictor %h", $time, exp_r, p);
      errors++;
    end
    pending_rsp.push_back(p);
    start <= 1'b0;
  endtask

  function automatic req_t mk(logic [1:0] a, logic [7:0] id, logic [15:0] b,
                              logic [6:0] pr);
    req_t r;
    r.action = a; r.task_id = id; r.burst_time = b; r.task_priority = pr;
    return r;
  endfunction

  typedef struct {
    req_t r;
    logic has_exp;
    rsp_t e;
  } row_t;

  row_t   rows[$];
  req_t   rr;
  rsp_t   ex;
  int     w;
  int     n;

  initial begin
    errors = 0; n_rsp = 0; n_full = 0; n_empty = 0; n_fin = 0; cycle = 0;
    sched_slice = '0; sched_clock = '0; sched_sum = '0; sched_steps = '0;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    ex = '0; ex.status = StEmpty;
    rows.push_back('{mk(ActServe, 8'd0, 16'd0, 7'd0), 1'b1, ex});
    ex = '0;
    rows.push_back('{mk(ActBegin, 8'd0, 16'd0, 7'd0), 1'b1, ex});
    rows.push_back('{mk(2'd3, 8'hFF, 16'hFFFF, 7'h7F), 1'b1, ex});
    ex.queue_count = 5'd1;
    rows.push_back('{mk(ActInsert, 8'hFF, 16'hFFFF, 7'h7F), 1'b1, ex});
    rows.push_back('{mk(ActInsert, 8'h00, 16'h0000, 7'h00), 1'b0, ex});
    rows.push_back('{mk(ActServe, 8'd0, 16'd0, 7'd0), 1'b0, ex});
    rows.push_back('{mk(ActServe, 8'd0, 16'd0, 7'd0), 1'b0, ex});
    for (int k = 0; k < 16; k++)
      rows.push_back('{mk(ActInsert, 8'(k + 1), 16'(k * 4097), 7'(k * 9)), 1'b0, ex});
    rows.push_back('{mk(ActBegin, 8'd0, 16'd0, 7'd0), 1'b0, ex});
    rows.push_back('{mk(ActServe, 8'd0, 16'd0, 7'd0), 1'b0, ex});
    foreach (rows[k]) send_item(rows[k].r, rows[k].has_exp, rows[k].e);

    // random part: mostly fill, latch, serve runs
    n = 0;
    while (n < 1500) begin
      if (n == 700) begin
        // hold off until every pending result has come back
        while (pending_rsp.size() != 0) @(posedge clk_i);
        repeat (80) @(posedge clk_i);
      end
      w = $urandom_range(0, 99);
      if (w < 40) begin
        rr = mk(ActInsert, 8'($urandom), ($urandom_range(0, 3) == 0) ?
                16'($urandom) : 16'($urandom_range(0, 300)), 7'($urandom));
        // occasional ageing pile-up for the negative priority range
        if ($urandom_range(0, 9) == 0) rr.task_priority = 7'd0;
      end else if (w < 48) rr = mk(ActBegin, 8'($urandom), 16'($urandom), 7'($urandom));
      else if (w < 97) rr = mk(ActServe, 8'($urandom), 16'($urandom), 7'($urandom));
      else rr = mk(2'd3, 8'($urandom), 16'($urandom), 7'($urandom));
      send_item(rr, 1'b0, '0);
      n++;
    end

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d results: %0d full inserts, %0d empty serves, %0d finishes",
             n_rsp, n_full, n_empty, n_fin);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
